>>> design/mhpq_pkg.sv
// Package for the max-heap priority queue: sequencer states, operation codes
// and result status codes. It has no dependencies.
package mhpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 9;
  localparam int STAT_W  = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DN_LOAD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

endpackage

>>> design/mhpq_mem.sv
// Key store of the max-heap priority queue: one write port and two read
// ports with registered read data. It depends on mhpq_pkg for the key width.
module mhpq_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic signed [mhpq_pkg::KEY_W-1:0] wr_data,
  input  logic [AW-1:0]                 rd_addr_a,
  input  logic [AW-1:0]                 rd_addr_b,
  output logic signed [mhpq_pkg::KEY_W-1:0] rd_data_a,
  output logic signed [mhpq_pkg::KEY_W-1:0] rd_data_b
);
  import mhpq_pkg::*;

  logic signed [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> design/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: handshake, sequencer and result
// register. It depends on mhpq_pkg and instantiates mhpq_mem.
//
// Usage. The input channel (in_valid, in_stall, op, key_in) carries one
// operation per transaction: insert key_in, or delete the maximum. Every
// input transaction yields exactly one output transaction (out_valid,
// out_stall, removed_key, status, count): the removed maximum for a
// successful delete and zero otherwise, a status of ok, empty or full, and
// the number of keys held afterwards.
// Operation. One operation at a time walks the heap through a single key
// memory with two registered read ports: each level of a sift is a read
// state and then a compare-and-move state, a delete first fetches the root and
// last key together, and every operation ends by loading the output register.
// in_stall is high while an operation is in progress.
// Stalls. The result sits in an output register; while the receiver stalls
// it holds, and the block still takes the next transaction. When that one
// finishes before the register frees up, the block waits holding its result.
// Reset. rst clears the count and the control state; the key memory is not
// cleared, because only entries below the count are ever used.
module max_heap_priority_queue #(
  parameter int CAPACITY = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   key_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mhpq_pkg::KEY_W-1:0]   removed_key,
  output logic [mhpq_pkg::STAT_W-1:0]       status,
  output logic [mhpq_pkg::COUNT_W-1:0]      count
);
  import mhpq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;

  state_t state, state_next;

  logic [CW-1:0]          cnt, cnt_next;
  logic [IW-1:0]          pos, pos_next;
  logic signed [KEY_W-1:0] key_hold, key_hold_next;
  logic signed [KEY_W-1:0] rem_hold, rem_hold_next;
  logic [STAT_W-1:0]      stat_hold, stat_hold_next;

  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  logic [IW-1:0]          rd_addr_a, rd_addr_b;
  logic signed [KEY_W-1:0] rd_data_a, rd_data_b;

  logic                   in_acc;
  logic                   out_free;
  logic [IW-1:0]          parent;
  logic [XW-1:0]          left_x, right_x;
  logic                   left_ok, right_ok;
  logic                   take_left, take_right;

  mhpq_mem #(
    .DEPTH(CAPACITY),
    .AW   (IW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Tree navigation for the current position.
  assign parent   = IW'((pos - 1'b1) >> 1);
  assign left_x   = (XW'(pos) << 1) + XW'(1);
  assign right_x  = left_x + XW'(1);
  assign left_ok  = left_x < XW'(cnt);
  assign right_ok = right_x < XW'(cnt);

  // The compare logic of a sift-down step: the larger child wins only
  // when it is strictly greater than the key being moved, the left on a tie.
  assign take_left  = left_ok && (rd_data_a > key_hold);
  assign take_right = right_ok &&
                      (rd_data_b > (take_left ? rd_data_a : key_hold));

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pos_next       = pos;
    key_hold_next  = key_hold;
    rem_hold_next  = rem_hold;
    stat_hold_next = stat_hold;
    wr_en          = 1'b0;
    wr_addr        = pos;
    wr_data        = key_hold;
    rd_addr_a      = IW'(left_x);
    rd_addr_b      = IW'(right_x);

    case (state)
      S_IDLE: begin
        rd_addr_a = '0;
        rd_addr_b = IW'(cnt - 1'b1);
        if (in_acc) begin
          rem_hold_next  = '0;
          stat_hold_next = ST_OK;
          key_hold_next  = key_in;
          if (op == OP_INSERT) begin
            if (cnt >= CW'(CAPACITY)) begin
              stat_hold_next = ST_FULL;
              state_next     = S_FIN;
            end else begin
              pos_next   = IW'(cnt);
              cnt_next   = cnt + 1'b1;
              state_next = S_UP_RD;
            end
          end else begin
            if (cnt == '0) begin
              stat_hold_next = ST_EMPTY;
              state_next     = S_FIN;
            end else begin
              state_next = S_DN_LOAD;
            end
          end
        end
      end
      S_DN_LOAD: begin
        // Root and last key arrive together from the two read ports.
        rem_hold_next = rd_data_a;
        key_hold_next = rd_data_b;
        cnt_next      = cnt - 1'b1;
        pos_next      = '0;
        state_next    = S_DN_RD;
      end
      S_UP_RD: begin
        rd_addr_a = parent;
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (key_hold > rd_data_a) begin
          wr_data    = rd_data_a;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DN_RD: begin
        if (!left_ok) begin
          wr_en      = 1'b1;
          state_next = S_FIN;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (take_right) begin
          wr_data    = rd_data_b;
          pos_next   = IW'(right_x);
          state_next = S_DN_RD;
        end else if (take_left) begin
          wr_data    = rd_data_a;
          pos_next   = IW'(left_x);
          state_next = S_DN_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    key_hold  <= key_hold_next;
    rem_hold  <= rem_hold_next;
    stat_hold <= stat_hold_next;
    if (state == S_FIN && out_free) begin
      removed_key <= rem_hold;
      status      <= stat_hold;
      count       <= COUNT_W'(cnt);
    end
  end

endmodule
